>>> src/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the position change detector
// Fixed-point formats, CORDIC angle table, multiplier request types and codes.
// ----------------------------------------------------------------------------
package pcd_pkg;

   // fixed-point format and iteration counts
   localparam int FRAC_BITS    = 32;
   localparam int CORDIC_STEPS = 32;
   localparam int SQRT_STEPS   = 32;
   localparam int STEP_W       = $clog2((CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS);

   // field widths
   localparam int LAT_W     = 31;
   localparam int LON_W     = 32;
   localparam int ALT_W     = 21;
   localparam int DIST_W    = 35;
   localparam int DTHR_W    = 20;
   localparam int ATHR_W    = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 20;

   typedef logic signed [63:0] word_type;

   // source constants in Q62, and the count of 1e-7 degree units per pi
   localparam logic [63:0] PI_Q62         = 64'hC90FDAA22168C235;
   localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
   localparam logic [63:0] INV_GAIN_Q62   = 64'h26DD3B6A10D7969A;
   localparam logic [63:0] UNITS_PER_PI   = 64'd1800000000;

   // Q62 to working format, round half up
   function automatic logic [63:0] q62_to_q(input logic [63:0] v);
      return (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
   endfunction

   localparam word_type PI_Q      = word_type'(q62_to_q(PI_Q62));
   localparam word_type TWO_PI_Q  = PI_Q <<< 1;
   localparam word_type HALF_PI_Q = word_type'(q62_to_q(PI_Q62 >> 1));
   localparam word_type GAIN_Q    = word_type'(q62_to_q(INV_GAIN_Q62));
   localparam word_type ONE_Q     = word_type'(64'd1 << FRAC_BITS);
   localparam word_type EARTH_RADIUS_MM = 64'sd6371000000;

   // 1e-7 degree to radians, Q92
   localparam logic [63:0] UNIT_K =
      ((PI_Q62 / UNITS_PER_PI) << 30) + (((PI_Q62 % UNITS_PER_PI) << 30) / UNITS_PER_PI);

   // product shifts
   localparam int ANGLE_SHIFT = 93 - FRAC_BITS;

   // integer square root rescale from Q31 to working format
   localparam int SQRT_UP   = (FRAC_BITS >= 31) ? FRAC_BITS - 31 : 0;
   localparam int SQRT_DOWN = (FRAC_BITS >= 31) ? 0 : 31 - FRAC_BITS;
   localparam logic [63:0] SQRT_ROUND = (SQRT_DOWN > 0) ? (64'd1 << (SQRT_DOWN - 1)) : 64'd0;

   // arctangent table: pi/4, then Taylor series of atan(2^-i) in Q62
   typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_type;

   function automatic atan_tab_type build_atan_table();
      atan_tab_type tab;
      logic [63:0]  sum;
      logic [63:0]  term;
      int unsigned  pw;
      tab    = '0;
      tab[0] = q62_to_q(QUARTER_PI_Q62);
      for (int unsigned i = 1; i < CORDIC_STEPS; i++) begin
         sum = '0;
         for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
            pw   = 62 - i * (2 * k + 1);
            term = (64'd1 << pw) / 64'(2 * k + 1);
            if (k[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tab[i] = q62_to_q(sum);
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_table();

   // result cause codes
   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_MOVE     = 2'd1,
      CAUSE_ALTITUDE = 2'd2
   } cause_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTITUDE_THRESHOLD = 1'd1;

   // multiplier product scaling
   typedef enum logic {
      SHIFT_FRAC  = 1'b0,
      SHIFT_ANGLE = 1'b1
   } shift_sel_type;

   typedef struct packed {
      logic          start;
      word_type      a;
      word_type      b;
      shift_sel_type sel;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } mul_rsp_type;

endpackage

>>> src/pcd_req_if.sv
// ----------------------------------------------------------------------------
// pcd_req_if: fix input channel
// Valid/ready channel carrying one GPS fix per transfer.
// ----------------------------------------------------------------------------
interface pcd_req_if import pcd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    location_fresh;
   logic signed [LAT_W-1:0] latitude;
   logic signed [LON_W-1:0] longitude;
   logic                    altitude_fresh;
   logic signed [ALT_W-1:0] altitude_cm;

   modport source (
      output valid, location_fresh, latitude, longitude, altitude_fresh, altitude_cm,
      input  ready
   );

   modport sink (
      input  valid, location_fresh, latitude, longitude, altitude_fresh, altitude_cm,
      output ready
   );
endinterface

>>> src/pcd_rsp_if.sv
// ----------------------------------------------------------------------------
// pcd_rsp_if: decision output channel
// Valid/ready channel carrying one decision per transfer.
// ----------------------------------------------------------------------------
interface pcd_rsp_if import pcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              updated;
   logic [1:0]        cause;
   logic [DIST_W-1:0] distance_mm;

   modport source (
      output valid, updated, cause, distance_mm,
      input  ready
   );

   modport sink (
      input  valid, updated, cause, distance_mm,
      output ready
   );
endinterface

>>> src/pcd_mul.sv
// ----------------------------------------------------------------------------
// pcd_mul: shared 64x64 multiplier with rounding shift
// Sign-magnitude product built from four 32x32 partial products over
// several cycles, rounded to nearest (ties away from zero), kept to 62 bits.
// ----------------------------------------------------------------------------
module pcd_mul import pcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   typedef enum logic [4:0] {
      MS_IDLE = 5'b00001,
      MS_PROD = 5'b00010,
      MS_ACC  = 5'b00100,
      MS_RND  = 5'b01000,
      MS_NEG  = 5'b10000
   } mstate_type;

   mstate_type    state_ff, state_in;
   logic [1:0]    k_ff, k_in;
   logic          done_ff, done_in;
   logic [63:0]   ua_ff, ua_in;
   logic [63:0]   ub_ff, ub_in;
   logic          neg_ff, neg_in;
   shift_sel_type sel_ff, sel_in;
   logic [63:0]   pp_ff, pp_in;
   logic [127:0]  acc_ff, acc_in;
   logic [63:0]   r_ff, r_in;
   word_type      result_ff, result_in;

   logic [31:0]   a_part;
   logic [31:0]   b_part;
   logic [1:0]    pp_pos;
   logic [6:0]    sh;
   logic [127:0]  rounded;

   // operand halves and rounding shift
   always_comb begin
      a_part  = ua_ff[{k_ff[1], 5'd0} +: 32];
      b_part  = ub_ff[{k_ff[0], 5'd0} +: 32];
      pp_pos  = {1'b0, k_ff[1]} + {1'b0, k_ff[0]};
      sh      = (sel_ff == SHIFT_ANGLE) ? 7'(ANGLE_SHIFT) : 7'(FRAC_BITS);
      rounded = (acc_ff + (128'd1 << (sh - 7'd1))) >> sh;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      done_in   = 1'b0;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      neg_in    = neg_ff;
      sel_in    = sel_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      result_in = result_ff;
      case (state_ff)
         MS_IDLE: begin
            if (req.start) begin
               ua_in    = req.a[63] ? 64'(-req.a) : 64'(req.a);
               ub_in    = req.b[63] ? 64'(-req.b) : 64'(req.b);
               neg_in   = req.a[63] ^ req.b[63];
               sel_in   = req.sel;
               acc_in   = '0;
               k_in     = '0;
               state_in = MS_PROD;
            end
         end
         MS_PROD: begin
            pp_in    = a_part * b_part;
            state_in = MS_ACC;
         end
         MS_ACC: begin
            acc_in = acc_ff + (128'(pp_ff) << {pp_pos, 5'd0});
            k_in   = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? MS_RND : MS_PROD;
         end
         MS_RND: begin
            r_in     = {2'b00, rounded[61:0]};
            state_in = MS_NEG;
         end
         MS_NEG: begin
            result_in = neg_ff ? -word_type'(r_ff) : word_type'(r_ff);
            done_in   = 1'b1;
            state_in  = MS_IDLE;
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         k_ff     <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff    <= neg_in;
      sel_ff    <= sel_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      r_ff      <= r_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

>>> src/position_change_detector.sv
// ----------------------------------------------------------------------------
// position_change_detector: GPS fix change detector
// Haversine distance from the stored position by CORDIC and a shared
// multiplier; flags horizontal movement or altitude change against
// programmable thresholds.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_bus   in         valid/ready        location_fresh, latitude, longitude,
//                                          altitude_fresh, altitude_cm
//  rsp_bus   out        valid/ready        updated, cause, distance_mm
//  csr_*     in         write enable only  csr_index, csr_write_data
//
//  A fix with a fresh location takes three sin/cos CORDIC runs, two
//  vectoring runs and a 32-step square root, each one step a cycle, plus
//  eight passes through the shared multiplier (fewer if the first vectoring
//  result is not positive). A fix without a fresh location skips them all.
//  req_bus.ready is high only while the sequencer is idle; a finished
//  decision waits in the output register until rsp_bus.ready.
//  Reset is synchronous; thresholds return to 500 mm and 100 cm, stored
//  position and altitude to zero.
// ----------------------------------------------------------------------------
module position_change_detector import pcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pcd_req_if.sink               req_bus,
   pcd_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_ANGMUL = 14'b00000000000010,
      ST_REDUCE = 14'b00000000000100,
      ST_FOLD   = 14'b00000000001000,
      ST_ROTATE = 14'b00000000010000,
      ST_SAVE   = 14'b00000000100000,
      ST_PQMUL  = 14'b00000001000000,
      ST_VEC1   = 14'b00000010000000,
      ST_MMUL   = 14'b00000100000000,
      ST_WMUL   = 14'b00001000000000,
      ST_SQRT   = 14'b00010000000000,
      ST_VEC2   = 14'b00100000000000,
      ST_DMUL   = 14'b01000000000000,
      ST_FINISH = 14'b10000000000000
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] i_ff, i_in;
   logic [1:0]        ang_ff, ang_in;
   logic              pq_ff, pq_in;
   logic              flip_ff, flip_in;
   logic              issued_ff, issued_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // configuration and stored fix
   logic [DTHR_W-1:0] dist_thr_ff, dist_thr_in;
   logic [ATHR_W-1:0] alt_thr_ff, alt_thr_in;
   logic [LAT_W-1:0]  last_lat_ff, last_lat_in;
   logic [LON_W-1:0]  last_lon_ff, last_lon_in;
   logic [ALT_W-1:0]  last_alt_ff, last_alt_in;

   // captured fix and datapath
   logic              loc_fresh_ff, loc_fresh_in;
   logic [LAT_W-1:0]  lat_ff, lat_in;
   logic [LON_W-1:0]  lon_ff, lon_in;
   logic              alt_fresh_ff, alt_fresh_in;
   logic [ALT_W-1:0]  alt_ff, alt_in;
   word_type          x_ff, x_in;
   word_type          y_ff, y_in;
   word_type          z_ff, z_in;
   word_type          s1_ff, s1_in;
   word_type          c2_ff, c2_in;
   word_type          s2_ff, s2_in;
   word_type          cm_ff, cm_in;
   word_type          m_ff, m_in;
   word_type          dist_ff, dist_in;
   logic              rsp_updated_ff, rsp_updated_in;
   cause_type         rsp_cause_ff, rsp_cause_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   mul_req_type       mul_req;
   mul_rsp_type       mul_rsp;

   logic              accept;
   logic              last_step;
   logic              mul_state;
   logic              sigma;
   word_type          xs, ys, atan_i;
   word_type          cx, cy, cz;
   word_type          trial, sq_n, sq_res;
   word_type          flip_x, flip_y;
   word_type          abs_r;
   word_type          lat1, lat2, lon1, lon2;
   word_type          angle_op;
   logic              moved;
   logic signed [ALT_W:0] alt_diff;
   logic [ALT_W:0]    alt_abs;
   logic              alt_hit;

   assign accept = req_bus.valid && req_bus.ready;

   // shared multiplier
   pcd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // sign-extended coordinates and angle operands
   always_comb begin
      lat1 = {{(64 - LAT_W){last_lat_ff[LAT_W-1]}}, last_lat_ff};
      lat2 = {{(64 - LAT_W){lat_ff[LAT_W-1]}}, lat_ff};
      lon1 = {{(64 - LON_W){last_lon_ff[LON_W-1]}}, last_lon_ff};
      lon2 = {{(64 - LON_W){lon_ff[LON_W-1]}}, lon_ff};
      case (ang_ff)
         2'd0:    angle_op = lat2 - lat1;
         2'd1:    angle_op = lon2 - lon1;
         default: angle_op = lat1 + lat2;
      endcase
   end

   // CORDIC step: rotation steers by z, vectoring by y
   always_comb begin
      xs     = x_ff >>> i_ff;
      ys     = y_ff >>> i_ff;
      atan_i = word_type'(ATAN_TAB[i_ff]);
      sigma  = (state_ff == ST_ROTATE) ? !z_ff[63] : y_ff[63];
      cx     = sigma ? x_ff - ys : x_ff + ys;
      cy     = sigma ? y_ff + xs : y_ff - xs;
      cz     = sigma ? z_ff - atan_i : z_ff + atan_i;
   end

   // square-root digit step: x holds the remainder, y the root, z the bit
   always_comb begin
      trial = y_ff + z_ff;
      if (x_ff >= trial) begin
         sq_n   = x_ff - trial;
         sq_res = (y_ff >>> 1) + z_ff;
      end else begin
         sq_n   = x_ff;
         sq_res = y_ff >>> 1;
      end
   end

   // misc datapath helpers
   always_comb begin
      last_step = (state_ff == ST_SQRT) ? (i_ff == STEP_W'(SQRT_STEPS - 1))
                                        : (i_ff == STEP_W'(CORDIC_STEPS - 1));
      flip_x    = flip_ff ? -x_ff : x_ff;
      flip_y    = flip_ff ? -y_ff : y_ff;
      abs_r     = mul_rsp.result[63] ? -mul_rsp.result : mul_rsp.result;
      mul_state = (state_ff == ST_ANGMUL) || (state_ff == ST_PQMUL) ||
                  (state_ff == ST_MMUL) || (state_ff == ST_WMUL) ||
                  (state_ff == ST_DMUL);
   end

   // multiplier operands
   always_comb begin
      mul_req.start = mul_state && !issued_ff;
      mul_req.a     = x_ff;
      mul_req.b     = GAIN_Q;
      mul_req.sel   = SHIFT_FRAC;
      case (state_ff)
         ST_ANGMUL: begin
            mul_req.a   = angle_op;
            mul_req.b   = word_type'(UNIT_K);
            mul_req.sel = SHIFT_ANGLE;
         end
         ST_PQMUL: begin
            mul_req.a = pq_ff ? cm_ff : s1_ff;
            mul_req.b = pq_ff ? s2_ff : c2_ff;
         end
         ST_WMUL: begin
            mul_req.a = ONE_Q - m_ff;
            mul_req.b = ONE_Q + m_ff;
         end
         ST_DMUL: begin
            mul_req.a = z_ff <<< 1;
            mul_req.b = EARTH_RADIUS_MM;
         end
         default: begin
            mul_req.a = x_ff;
         end
      endcase
   end

   // decision on the finished fix
   always_comb begin
      moved    = loc_fresh_ff && (64'(dist_ff) > 64'(dist_thr_ff));
      alt_diff = signed'({alt_ff[ALT_W-1], alt_ff}) -
                 signed'({last_alt_ff[ALT_W-1], last_alt_ff});
      alt_abs  = alt_diff[ALT_W] ? (ALT_W + 1)'(-alt_diff) : (ALT_W + 1)'(alt_diff);
      alt_hit  = !moved && alt_fresh_ff && (alt_abs >= (ALT_W + 1)'(alt_thr_ff));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      ang_in         = ang_ff;
      pq_in          = pq_ff;
      flip_in        = flip_ff;
      issued_in      = issued_ff;
      rsp_valid_in   = rsp_valid_ff;
      dist_thr_in    = dist_thr_ff;
      alt_thr_in     = alt_thr_ff;
      last_lat_in    = last_lat_ff;
      last_lon_in    = last_lon_ff;
      last_alt_in    = last_alt_ff;
      loc_fresh_in   = loc_fresh_ff;
      lat_in         = lat_ff;
      lon_in         = lon_ff;
      alt_fresh_in   = alt_fresh_ff;
      alt_in         = alt_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      s1_in          = s1_ff;
      c2_in          = c2_ff;
      s2_in          = s2_ff;
      cm_in          = cm_ff;
      m_in           = m_ff;
      dist_in        = dist_ff;
      rsp_updated_in = rsp_updated_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_dist_in    = rsp_dist_ff;

      // output transfer
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // multiplier issue tracking
      if (mul_req.start) begin
         issued_in = 1'b1;
      end
      if (mul_rsp.done) begin
         issued_in = 1'b0;
      end

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DISTANCE_THRESHOLD: dist_thr_in = csr_write_data[DTHR_W-1:0];
            CSR_ALTITUDE_THRESHOLD: alt_thr_in  = csr_write_data[ATHR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               loc_fresh_in = req_bus.location_fresh;
               lat_in       = req_bus.latitude;
               lon_in       = req_bus.longitude;
               alt_fresh_in = req_bus.altitude_fresh;
               alt_in       = req_bus.altitude_cm;
               dist_in      = '0;
               ang_in       = 2'd0;
               state_in     = req_bus.location_fresh ? ST_ANGMUL : ST_FINISH;
            end
         end
         ST_ANGMUL: begin
            if (mul_rsp.done) begin
               z_in     = mul_rsp.result;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (z_ff > PI_Q) begin
               z_in = z_ff - TWO_PI_Q;
            end else if (z_ff < -PI_Q) begin
               z_in = z_ff + TWO_PI_Q;
            end
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            flip_in = 1'b0;
            if (z_ff > HALF_PI_Q) begin
               z_in    = z_ff - PI_Q;
               flip_in = 1'b1;
            end else if (z_ff < -HALF_PI_Q) begin
               z_in    = z_ff + PI_Q;
               flip_in = 1'b1;
            end
            x_in     = GAIN_Q;
            y_in     = '0;
            i_in     = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            x_in = cx;
            y_in = cy;
            z_in = cz;
            i_in = i_ff + 1'b1;
            if (last_step) begin
               state_in = ST_SAVE;
            end
         end
         ST_SAVE: begin
            case (ang_ff)
               2'd0: begin
                  s1_in = flip_y;
               end
               2'd1: begin
                  c2_in = flip_x;
                  s2_in = flip_y;
               end
               default: begin
                  cm_in = flip_x;
               end
            endcase
            if (ang_ff == 2'd2) begin
               pq_in    = 1'b0;
               state_in = ST_PQMUL;
            end else begin
               ang_in   = ang_ff + 2'd1;
               state_in = ST_ANGMUL;
            end
         end
         ST_PQMUL: begin
            if (mul_rsp.done) begin
               if (!pq_ff) begin
                  x_in  = abs_r;
                  pq_in = 1'b1;
               end else begin
                  y_in     = abs_r;
                  z_in     = '0;
                  i_in     = '0;
                  state_in = ST_VEC1;
               end
            end
         end
         ST_VEC1: begin
            x_in = cx;
            y_in = cy;
            z_in = cz;
            i_in = i_ff + 1'b1;
            if (last_step) begin
               state_in = ST_MMUL;
            end
         end
         ST_MMUL: begin
            if (mul_rsp.done) begin
               if (mul_rsp.result <= 0) begin
                  state_in = ST_FINISH;
               end else begin
                  m_in     = (mul_rsp.result > ONE_Q) ? ONE_Q : mul_rsp.result;
                  state_in = ST_WMUL;
               end
            end
         end
         ST_WMUL: begin
            if (mul_rsp.done) begin
               x_in     = mul_rsp.result[63] ? word_type'(0)
                                             : (mul_rsp.result <<< (62 - FRAC_BITS));
               y_in     = '0;
               z_in     = word_type'(64'd1 << 62);
               i_in     = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            i_in = i_ff + 1'b1;
            if (last_step) begin
               x_in     = word_type'(((64'(sq_res) + SQRT_ROUND) >> SQRT_DOWN) << SQRT_UP);
               y_in     = m_ff;
               z_in     = '0;
               i_in     = '0;
               state_in = ST_VEC2;
            end else begin
               x_in = sq_n;
               y_in = sq_res;
               z_in = z_ff >>> 2;
            end
         end
         ST_VEC2: begin
            x_in = cx;
            y_in = cy;
            z_in = cz;
            i_in = i_ff + 1'b1;
            if (last_step) begin
               z_in     = cz[63] ? word_type'(0) : cz;
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            if (mul_rsp.done) begin
               dist_in  = mul_rsp.result;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_updated_in = moved || alt_hit;
               rsp_cause_in   = moved ? CAUSE_MOVE : (alt_hit ? CAUSE_ALTITUDE : CAUSE_NONE);
               rsp_dist_in    = dist_ff[DIST_W-1:0];
               if (loc_fresh_ff) begin
                  last_lat_in = lat_ff;
                  last_lon_in = lon_ff;
               end
               if (!moved && alt_fresh_ff) begin
                  last_alt_in = alt_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         ang_ff       <= '0;
         pq_ff        <= 1'b0;
         flip_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dist_thr_ff  <= DTHR_W'(500);
         alt_thr_ff   <= ATHR_W'(100);
         last_lat_ff  <= '0;
         last_lon_ff  <= '0;
         last_alt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         ang_ff       <= ang_in;
         pq_ff        <= pq_in;
         flip_ff      <= flip_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_thr_ff  <= dist_thr_in;
         alt_thr_ff   <= alt_thr_in;
         last_lat_ff  <= last_lat_in;
         last_lon_ff  <= last_lon_in;
         last_alt_ff  <= last_alt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      loc_fresh_ff   <= loc_fresh_in;
      lat_ff         <= lat_in;
      lon_ff         <= lon_in;
      alt_fresh_ff   <= alt_fresh_in;
      alt_ff         <= alt_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      s1_ff          <= s1_in;
      c2_ff          <= c2_in;
      s2_ff          <= s2_in;
      cm_ff          <= cm_in;
      m_ff           <= m_in;
      dist_ff        <= dist_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_cause_ff   <= rsp_cause_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.updated     = rsp_updated_ff;
   assign rsp_bus.cause       = rsp_cause_ff;
   assign rsp_bus.distance_mm = rsp_dist_ff;

endmodule

>>> src/pcd_checker.sv
// ----------------------------------------------------------------------------
// pcd_checker: port-level checks for the position change detector
// Watches the channel ports and flags sequencing or result slips.
// ----------------------------------------------------------------------------
module pcd_checker import pcd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_updated,
   input logic [1:0]        rsp_cause,
   input logic [DIST_W-1:0] rsp_distance_mm
);

   // one fix at a time: after a transfer in, the block is busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a fix was in progress");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_updated) &&
      $stable(rsp_cause) && $stable(rsp_distance_mm))
      else $error("stalled result changed");

   // flag and cause agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_updated == (rsp_cause != CAUSE_NONE)) &&
      (rsp_cause == CAUSE_NONE || rsp_cause == CAUSE_MOVE || rsp_cause == CAUSE_ALTITUDE))
      else $error("updated flag and cause disagree");

   // movement needs a nonzero distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cause == CAUSE_MOVE |-> rsp_distance_mm != '0)
      else $error("movement flagged with zero distance");

endmodule

bind position_change_detector pcd_checker u_pcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_updated     (rsp_bus.updated),
   .rsp_cause       (rsp_bus.cause),
   .rsp_distance_mm (rsp_bus.distance_mm)
);

>>> test/position_change_detector_tb.sv
// ----------------------------------------------------------------------------
// position_change_detector_tb: self-checking bench for the GPS change detector
// Drives GPS fixes over the request channel with random gaps and back-pressure,
// predicts each decision with a fixed-point haversine model of its own, and
// compares every response field by field. Thresholds change between phases.
// ----------------------------------------------------------------------------
module position_change_detector_tb;
   import pcd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT  = 2000000;
   localparam int  DRAIN_CYCLES = 400;

   typedef struct {
      bit                      location_fresh;
      logic signed [LAT_W-1:0] latitude;
      logic signed [LON_W-1:0] longitude;
      bit                      altitude_fresh;
      logic signed [ALT_W-1:0] altitude_cm;
   } fix_type;

   typedef struct {
      bit                updated;
      cause_type         cause;
      logic [DIST_W-1:0] distance_mm;
   } decision_type;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pcd_req_if req_bus ();
   pcd_rsp_if rsp_bus ();

   position_change_detector uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // bench state
   fix_type      pending_fixes[$];
   decision_type expected_decisions[$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           quiet_mode  = 1'b0;
   bit           req_taken   = 1'b0;

   // predictor state
   longint signed atan_step[CORDIC_STEPS];
   longint signed gain_fx, pi_fx, half_pi_fx, unit_scale;
   logic [DTHR_W-1:0] dist_limit_mm;
   logic [ATHR_W-1:0] alt_limit_cm;
   logic signed [LAT_W-1:0] held_latitude;
   logic signed [LON_W-1:0] held_longitude;
   logic signed [ALT_W-1:0] held_altitude;

   // ------------------------------------------------------------------
   // fixed-point predictor
   // ------------------------------------------------------------------
   function automatic longint signed round_q62(logic [63:0] v);
      return longint'((v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
   endfunction

   function automatic void init_constants();
      logic [63:0] sum, term;
      atan_step[0] = round_q62(QUARTER_PI_Q62);
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         sum = '0;
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
            sum  = k[0] ? sum - term : sum + term;
         end
         atan_step[i] = round_q62(sum);
      end
      gain_fx    = round_q62(INV_GAIN_Q62);
      pi_fx      = round_q62(PI_Q62);
      half_pi_fx = round_q62(PI_Q62 >> 1);
      unit_scale = longint'(((PI_Q62 / UNITS_PER_PI) << 30)
                   + (((PI_Q62 % UNITS_PER_PI) << 30) / UNITS_PER_PI));
   endfunction

   // product scaled by 2^-s, rounded half away from zero
   function automatic longint signed scaled_product(longint signed a, longint signed b,
                                                   int s);
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      logic [63:0]  r;
      bit           neg;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? 64'(-a) : 64'(a);
      ub   = (b < 0) ? 64'(-b) : 64'(b);
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod + (128'd1 << (s - 1));
      r    = 64'(prod >> s) & 64'h3FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic void rotate_sin_cos(longint signed th, output longint signed c,
                                          output longint signed s);
      longint signed x, y, dx, dy;
      bit flip;
      x = gain_fx;
      y = 0;
      flip = 1'b0;
      while (th > pi_fx) th -= 2 * pi_fx;
      while (th < -pi_fx) th += 2 * pi_fx;
      if (th > half_pi_fx) begin
         th -= pi_fx;
         flip = 1'b1;
      end else if (th < -half_pi_fx) begin
         th += pi_fx;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx; y += dy; th -= atan_step[i];
         end else begin
            x += dx; y -= dy; th += atan_step[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // vectoring run: grown magnitude returned, angle through ang
   function automatic longint signed vector_mag(longint signed x, longint signed y,
                                                output longint signed ang);
      longint signed dx, dy;
      ang = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; ang += atan_step[i];
         end else begin
            x -= dx; y += dy; ang -= atan_step[i];
         end
      end
      return x;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint signed haversine_mm(longint signed lat1, longint signed lon1,
                                                  longint signed lat2, longint signed lon2);
      longint signed one_fx, s1, c1, s2, c2, sm, cm, p, q, m, w, x, z;
      one_fx = longint'(1) << FRAC_BITS;
      rotate_sin_cos(scaled_product(lat2 - lat1, unit_scale, ANGLE_SHIFT), c1, s1);
      rotate_sin_cos(scaled_product(lon2 - lon1, unit_scale, ANGLE_SHIFT), c2, s2);
      rotate_sin_cos(scaled_product(lat1 + lat2, unit_scale, ANGLE_SHIFT), cm, sm);
      p = scaled_product(s1, c2, FRAC_BITS);
      q = scaled_product(cm, s2, FRAC_BITS);
      if (p < 0) p = -p;
      if (q < 0) q = -q;
      m = scaled_product(vector_mag(p, q, z), gain_fx, FRAC_BITS);
      // coincident points give an exact zero
      if (m <= 0) return 0;
      if (m > one_fx) m = one_fx;
      w = scaled_product(one_fx - m, one_fx + m, FRAC_BITS);
      if (w < 0) w = 0;
      x = longint'(floor_sqrt(64'(w) << (62 - FRAC_BITS)));
      if (FRAC_BITS >= 31) x = x << (FRAC_BITS - 31);
      else x = (x + (longint'(1) << (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
      void'(vector_mag(x, m, z));
      if (z < 0) z = 0;
      return scaled_product(2 * z, EARTH_RADIUS_MM, FRAC_BITS);
   endfunction

   function automatic decision_type predict_decision(fix_type f);
      decision_type d;
      longint signed span_mm, diff;
      d.updated = 1'b0;
      d.cause   = CAUSE_NONE;
      span_mm   = 0;
      if (f.location_fresh) begin
         span_mm = haversine_mm(held_latitude, held_longitude, f.latitude, f.longitude);
         if (64'(span_mm) > 64'(dist_limit_mm)) begin
            d.updated = 1'b1;
            d.cause   = CAUSE_MOVE;
         end
         held_latitude  = f.latitude;
         held_longitude = f.longitude;
      end
      if (!d.updated && f.altitude_fresh) begin
         diff = longint'(f.altitude_cm) - longint'(held_altitude);
         if (diff < 0) diff = -diff;
         if (diff >= longint'(alt_limit_cm)) begin
            d.updated = 1'b1;
            d.cause   = CAUSE_ALTITUDE;
         end
         held_altitude = f.altitude_cm;
      end
      d.distance_mm = DIST_W'(span_mm);
      return d;
   endfunction

   // ------------------------------------------------------------------
   // request driver: changes on the falling edge
   // ------------------------------------------------------------------
   int req_gap = 0;

   always @(negedge clock) begin
      fix_type f;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_fixes.size() != 0) begin
            f = pending_fixes.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.location_fresh <= f.location_fresh;
            req_bus.latitude       <= f.latitude;
            req_bus.longitude      <= f.longitude;
            req_bus.altitude_fresh <= f.altitude_fresh;
            req_bus.altitude_cm    <= f.altitude_cm;
            if (!quiet_mode && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 7);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response back-pressure in bursts
   int rsp_stall = 0;

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         rsp_stall = $urandom_range(1, 7) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor: samples transfers on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      fix_type      f;
      decision_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (req_taken) begin
         f.location_fresh = req_bus.location_fresh;
         f.latitude       = req_bus.latitude;
         f.longitude      = req_bus.longitude;
         f.altitude_fresh = req_bus.altitude_fresh;
         f.altitude_cm    = req_bus.altitude_cm;
         expected_decisions.push_back(predict_decision(f));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_decisions.size() == 0) begin
            $display("%0t: unexpected transfer updated=%0d cause=%0d distance=%0d",
                     $time, rsp_bus.updated, rsp_bus.cause, rsp_bus.distance_mm);
            error_count++;
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_bus.updated !== want.updated) begin
               $display("%0t: updated expected %0d actual %0d",
                        $time, want.updated, rsp_bus.updated);
               error_count++;
            end
            if (rsp_bus.cause !== want.cause) begin
               $display("%0t: cause expected %0d actual %0d",
                        $time, want.cause, rsp_bus.cause);
               error_count++;
            end
            if (rsp_bus.distance_mm !== want.distance_mm) begin
               $display("%0t: distance_mm expected %0d actual %0d",
                        $time, want.distance_mm, rsp_bus.distance_mm);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   logic signed [LAT_W-1:0] gen_latitude  = '0;
   logic signed [LON_W-1:0] gen_longitude = '0;
   logic signed [ALT_W-1:0] gen_altitude  = '0;

   task automatic queue_fix(bit lf, longint signed lat, longint signed lon, bit af,
                            longint signed alt);
      fix_type f;
      f.location_fresh = lf;
      f.latitude       = LAT_W'(lat);
      f.longitude      = LON_W'(lon);
      f.altitude_fresh = af;
      f.altitude_cm    = ALT_W'(alt);
      if (lf) begin
         gen_latitude  = f.latitude;
         gen_longitude = f.longitude;
      end
      if (af) gen_altitude = f.altitude_cm;
      pending_fixes.push_back(f);
   endtask

   // mostly small moves near the last fix, some jumps anywhere
   task automatic queue_random_fix();
      longint signed lat, lon, alt;
      int scale;
      scale = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
         lat = longint'($signed(LAT_W'($urandom)));
         lon = longint'($signed(LON_W'($urandom)));
      end else begin
         lat = longint'(gen_latitude)
               + $signed($urandom_range(0, 200 << (4 * scale))) - (100 << (4 * scale));
         lon = longint'(gen_longitude)
               + $signed($urandom_range(0, 200 << (4 * scale))) - (100 << (4 * scale));
      end
      if ($urandom_range(0, 3) == 0) alt = longint'($signed(ALT_W'($urandom)));
      else alt = longint'(gen_altitude) + $signed($urandom_range(0, 400)) - 200;
      queue_fix($urandom_range(0, 3) != 0, lat, lon, $urandom_range(0, 2) != 0, alt);
   endtask

   task automatic wait_drained();
      while (pending_fixes.size() != 0 || req_bus.valid || expected_decisions.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_DISTANCE_THRESHOLD) dist_limit_mm = DTHR_W'(value);
      else alt_limit_cm = ATHR_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] dist_settings[6];
      logic [CSR_DATA_W-1:0] alt_settings[6];
      init_constants();
      dist_limit_mm  = 500;
      alt_limit_cm   = 100;
      held_latitude  = '0;
      held_longitude = '0;
      held_altitude  = '0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DISTANCE_THRESHOLD;
      csr_write_data   = '0;
      req_bus.valid          = 1'b0;
      req_bus.location_fresh = 1'b0;
      req_bus.latitude       = '0;
      req_bus.longitude      = '0;
      req_bus.altitude_fresh = 1'b0;
      req_bus.altitude_cm    = '0;
      rsp_bus.ready          = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: same point, field extremes, antipodes, altitude edges
      queue_fix(1, 0, 0, 1, 0);
      queue_fix(1, 900000000, 1800000000, 1, 1000000);
      queue_fix(1, -900000000, -1800000000, 1, -100000);
      queue_fix(1, 900000000, 0, 0, 0);
      queue_fix(1, -900000000, 0, 1, -100000);
      queue_fix(1, 0, 1800000000, 1, -99901);
      queue_fix(1, 0, 0, 1, -99900);
      queue_fix(1, -(1 <<< 30), -(1 <<< 31), 1, -(1 <<< 20));
      queue_fix(1, (1 <<< 30) - 1, (1 <<< 31) - 1, 1, (1 <<< 20) - 1);
      queue_fix(1, (1 <<< 30) - 1, (1 <<< 31) - 1, 1, (1 <<< 20) - 1);
      queue_fix(1, (1 <<< 30) - 1 - 45, (1 <<< 31) - 1, 0, 0);
      queue_fix(1, (1 <<< 30) - 1 - 90, (1 <<< 31) - 1, 0, 0);
      queue_fix(0, 123, 456, 1, 0);
      queue_fix(0, 123, 456, 1, 99);
      queue_fix(0, 123, 456, 1, 199);
      queue_fix(0, 0, 0, 0, 5000);
      queue_fix(1, 450000000, 900000000, 1, 500);
      queue_fix(1, -450000000, -900000000, 1, 500);
      queue_fix(1, 10, -10, 1, 600);
      queue_fix(1, 10, -10, 1, 600);
      wait_drained();

      // threshold phases: zero, maxima, masking, random
      dist_settings = '{0, 1000000, 20'hFFFFF, 1000, 20, 0};
      alt_settings  = '{20'h20000, 100000, 20'hFFFFF, 1, 50, 100};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_DISTANCE_THRESHOLD,
                   (ph == 5) ? CSR_DATA_W'($urandom_range(0, 1000000)) : dist_settings[ph]);
         write_csr(CSR_ALTITUDE_THRESHOLD,
                   (ph == 5) ? CSR_DATA_W'($urandom_range(1, 100000)) : alt_settings[ph]);
         if (ph == 5) quiet_mode = 1'b1;
         for (int n = 0; n < 122; n++) queue_random_fix();
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
src/pcd_pkg.sv
src/pcd_req_if.sv
src/pcd_rsp_if.sv
src/pcd_mul.sv
src/position_change_detector.sv
src/pcd_checker.sv
test/position_change_detector_tb.sv
